FILE: sv/mexp_pkg.sv
package mexp_pkg;

  // operand widths
  localparam int EXP_BITS       = 63;
  localparam int MOD_BITS       = 31;
  localparam int BASE_BITS      = 63;
  localparam int PROD_BITS      = 2 * MOD_BITS;
  // the serial reducer takes the wider of the base and a full product
  localparam int RED_BITS       = (BASE_BITS > PROD_BITS) ? BASE_BITS : PROD_BITS;
  localparam int CNT_BITS       = $clog2(RED_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(RED_BITS - 1);

  // configuration port
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;
  localparam logic CFG_IDX_MODULUS = 1'b0;
  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE_RED,
    ST_BASE_SET,
    ST_CHECK,
    ST_MUL,
    ST_RED,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic red_step;
    logic base_set;
    logic mul_load;
    logic bit_update;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exp_zero;
  } dp_status_t;

  // datapath to one reducer lane
  typedef struct packed {
    logic load;
    logic step;
  } red_cmd_t;

endpackage

FILE: sv/modular_exponentiation_core.sv
// Each exponent bit takes a multiply, a bit-serial reduction of both products in
// parallel, an update and a check. The next input is taken once the result sits in
// the output register. Synchronous active-low reset clears the controller and sets
// the modulus to 1000000007.
module modular_exponentiation_core import mexp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BASE_BITS-1:0]     in_base,
  input  logic [EXP_BITS-1:0]      in_exponent,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [MOD_BITS-1:0]      out_power_result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [MOD_BITS-1:0] modulus_r, modulus_nxt;
  logic                reg_sel;
  dp_cmd_t             cmd;
  dp_status_t          status;

  assign reg_sel = (paddr[CFG_ADDR_BITS-1] == CFG_IDX_MODULUS);
  assign pready  = 1'b1;

  // modulus register write
  always_comb begin
    modulus_nxt = modulus_r;
    if (psel && penable && pwrite && reg_sel) begin
      modulus_nxt = pwdata[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  // register readback
  assign prdata = reg_sel ? {{(CFG_DATA_BITS-MOD_BITS){1'b0}}, modulus_r} : '0;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mexp_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .in_base      (in_base),
    .in_exponent  (in_exponent),
    .modulus      (modulus_r),
    .status       (status),
    .power_result (out_power_result)
  );

endmodule

FILE: sv/mexp_reducer.sv
module mexp_reducer import mexp_pkg::*; (
  input  logic                clk,
  input  red_cmd_t            cmd,
  input  logic [RED_BITS-1:0] dividend,
  input  logic [MOD_BITS-1:0] modulus,
  output logic [MOD_BITS-1:0] remainder
);

  logic [RED_BITS-1:0] shift_r, shift_nxt;
  logic [MOD_BITS-1:0] rem_r, rem_nxt;
  logic [MOD_BITS:0]   trial;
  logic [MOD_BITS:0]   diff;

  // bring in one dividend bit, subtract the modulus once if it fits
  assign trial = {rem_r, shift_r[RED_BITS-1]};
  assign diff  = trial - {1'b0, modulus};

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    if (cmd.load) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
    end else if (cmd.step) begin
      shift_nxt = {shift_r[RED_BITS-2:0], 1'b0};
      if (trial >= {1'b0, modulus}) begin
        rem_nxt = diff[MOD_BITS-1:0];
      end else begin
        rem_nxt = trial[MOD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign remainder = rem_r;

endmodule

FILE: sv/mexp_datapath.sv
module mexp_datapath import mexp_pkg::*; (
  input  logic                 clk,
  input  dp_cmd_t              cmd,
  input  logic [BASE_BITS-1:0] in_base,
  input  logic [EXP_BITS-1:0]  in_exponent,
  input  logic [MOD_BITS-1:0]  modulus,
  output dp_status_t           status,
  output logic [MOD_BITS-1:0]  power_result
);

  logic [EXP_BITS-1:0]  exp_r;
  logic [MOD_BITS-1:0]  sq_r;
  logic [MOD_BITS-1:0]  acc_r;
  logic [MOD_BITS-1:0]  result_r;
  logic [PROD_BITS-1:0] prod_acc;
  logic [PROD_BITS-1:0] prod_sq;
  logic [RED_BITS-1:0]  div_a;
  logic [RED_BITS-1:0]  div_b;
  logic [MOD_BITS-1:0]  rem_a;
  logic [MOD_BITS-1:0]  rem_b;
  red_cmd_t             red_a_cmd;
  red_cmd_t             red_b_cmd;

  // both products of one exponent bit go to their own reducer lane
  assign prod_acc = PROD_BITS'(acc_r) * PROD_BITS'(sq_r);
  assign prod_sq  = PROD_BITS'(sq_r) * PROD_BITS'(sq_r);

  // lane A reduces the base first, then the running result product
  assign div_a = cmd.start ? RED_BITS'(in_base) : RED_BITS'(prod_acc);
  assign div_b = RED_BITS'(prod_sq);

  assign red_a_cmd.load = cmd.start | cmd.mul_load;
  assign red_a_cmd.step = cmd.red_step;
  assign red_b_cmd.load = cmd.mul_load;
  assign red_b_cmd.step = cmd.red_step;

  mexp_reducer u_red_a (
    .clk       (clk),
    .cmd       (red_a_cmd),
    .dividend  (div_a),
    .modulus   (modulus),
    .remainder (rem_a)
  );

  mexp_reducer u_red_b (
    .clk       (clk),
    .cmd       (red_b_cmd),
    .dividend  (div_b),
    .modulus   (modulus),
    .remainder (rem_b)
  );

  // operand registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      exp_r <= in_exponent;
      acc_r <= MOD_BITS'(1);
    end
    if (cmd.base_set) begin
      sq_r <= rem_a;
    end
    if (cmd.bit_update) begin
      sq_r  <= rem_b;
      exp_r <= exp_r >> 1;
      if (exp_r[0]) begin
        acc_r <= rem_a;
      end
    end
  end

  // hold the finished result; a modulus below two gives zero
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_r <= (modulus < MOD_BITS'(2)) ? '0 : acc_r;
    end
  end

  assign status.exp_zero = (exp_r == '0);
  assign power_result    = result_r;

endmodule

FILE: sv/mexp_ctrl.sv
module mexp_ctrl import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output logic       in_stall,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_BASE_RED;
      end
      ST_BASE_RED: begin
        if (cnt_r == '0) state_nxt = ST_BASE_SET;
      end
      ST_BASE_SET: state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = status.exp_zero ? ST_FINISH : ST_MUL;
      end
      ST_MUL: state_nxt = ST_RED;
      ST_RED: begin
        if (cnt_r == '0) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_CHECK;
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // reduction step counter
  always_comb begin
    cnt_nxt = cnt_r;
    if ((state_r == ST_IDLE && in_valid) || state_r == ST_MUL) begin
      cnt_nxt = CNT_LAST;
    end else if (state_r == ST_BASE_RED || state_r == ST_RED) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_BASE_RED: cmd.red_step   = 1'b1;
      ST_BASE_SET: cmd.base_set   = 1'b1;
      ST_CHECK:    cmd            = '0;
      ST_MUL:      cmd.mul_load   = 1'b1;
      ST_RED:      cmd.red_step   = 1'b1;
      ST_UPDATE:   cmd.bit_update = 1'b1;
      ST_FINISH:   cmd.out_load   = slot_free;
      default:     cmd            = '0;
    endcase
  end

  // output valid: set on load, drop once the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
